// ----- rtl/core/weighted_joint_vertex_skinning_unit_defines.svh -----
// Assertion macros shared by the checker of the skinning unit.
`ifndef WEIGHTED_JOINT_VERTEX_SKINNING_UNIT_DEFINES_SVH
`define WEIGHTED_JOINT_VERTEX_SKINNING_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define WJS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define WJS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/wjs_pkg.sv -----
// Shared constants, codes and record types of the skinning unit.
`timescale 1ns / 1ps
package wjs_pkg;

  localparam int JOINT_SLOTS    = 256;
  localparam int WEIGHT_SLOTS   = 4096;
  localparam int MAX_PER_VERTEX = 16;

  localparam int JAW    = (JOINT_SLOTS > 1) ? $clog2(JOINT_SLOTS) : 1;
  localparam int WAW    = (WEIGHT_SLOTS > 1) ? $clog2(WEIGHT_SLOTS) : 1;
  localparam int NW     = $clog2(MAX_PER_VERTEX + 1);
  // Wide enough for slot plus count and for the largest table size.
  localparam int SUMW   = 18;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] CMD_JOINT   = 2'd0;
  localparam logic [1:0] CMD_WEIGHT  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [1:0] FAULT_OK    = 2'd0;
  localparam logic [1:0] FAULT_SAT   = 2'd1;
  localparam logic [1:0] FAULT_RANGE = 2'd2;
  localparam logic [1:0] FAULT_JOINT = 2'd3;

  typedef enum logic [1:0] {OP_JOINT, OP_WEIGHT, OP_COMPUTE} op_t;

  typedef struct packed {
    op_t                op;
    logic [11:0]        slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_w;
    logic [7:0]         joint_ref;
    logic [15:0]        bias;
    logic [NW-1:0]      n;
    logic               range_fault;
  } op_item_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic [7:0]         joint_ref;
    logic [15:0]        bias;
  } weight_rec_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } joint_rec_t;

  typedef struct packed {
    logic first;
    logic last;
    logic contrib;
    logic range_fault;
    logic joint_fault;
  } tag_t;

endpackage

// ----- rtl/core/wjs_channels.sv -----
// Valid/ready channel interfaces for command items and point items.
`timescale 1ns / 1ps
interface wjs_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [11:0]        slot;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  logic signed [15:0] rot_w;
  logic [7:0]         joint_ref;
  logic [15:0]        bias;
  logic [4:0]         count;

  modport source (output valid, command, slot, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
                  rot_w, joint_ref, bias, count, input ready);
  modport sink (input valid, command, slot, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
                rot_w, joint_ref, bias, count, output ready);
endinterface

interface wjs_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [1:0]         fault;

  modport source (output valid, point_x, point_y, point_z, fault, input ready);
  modport sink (input valid, point_x, point_y, point_z, fault, output ready);
endinterface

// ----- rtl/core/wjs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module wjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/wjs_front.sv -----
// Front end: accepts command items, classifies them and queues them.
`timescale 1ns / 1ps
module wjs_front import wjs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  wjs_cmd_if.sink  cmd_ch,
  output logic     q_valid,
  output op_item_t q_item,
  input  logic     q_pop
);

  op_item_t          fifo [QDEPTH];
  logic [QAW-1:0]    rd_ptr;
  logic [QAW-1:0]    wr_ptr;
  logic [QAW:0]      fill;
  op_item_t          cls;
  logic              keep;
  logic              push;
  logic [SUMW-1:0]   slot_w;
  logic [SUMW-1:0]   end_w;

  // Count saturation, range check; drops unknown commands and off-table writes.
  always_comb begin
    slot_w = SUMW'(cmd_ch.slot);
    cls.slot = cmd_ch.slot;
    cls.pos_x = cmd_ch.pos_x;
    cls.pos_y = cmd_ch.pos_y;
    cls.pos_z = cmd_ch.pos_z;
    cls.rot_x = cmd_ch.rot_x;
    cls.rot_y = cmd_ch.rot_y;
    cls.rot_z = cmd_ch.rot_z;
    cls.rot_w = cmd_ch.rot_w;
    cls.joint_ref = cmd_ch.joint_ref;
    cls.bias = cmd_ch.bias;
    if (SUMW'(cmd_ch.count) > SUMW'(MAX_PER_VERTEX)) begin
      cls.n = NW'(MAX_PER_VERTEX);
    end else begin
      cls.n = NW'(cmd_ch.count);
    end
    end_w = slot_w + SUMW'(cls.n);
    cls.range_fault = end_w > SUMW'(WEIGHT_SLOTS);
    unique case (cmd_ch.command)
      CMD_JOINT: begin
        cls.op = OP_JOINT;
        keep = slot_w < SUMW'(JOINT_SLOTS);
      end
      CMD_WEIGHT: begin
        cls.op = OP_WEIGHT;
        keep = slot_w < SUMW'(WEIGHT_SLOTS);
      end
      CMD_COMPUTE: begin
        cls.op = OP_COMPUTE;
        keep = 1'b1;
      end
      default: begin
        cls.op = OP_COMPUTE;
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_ch.ready = fill != (QAW + 1)'(QDEPTH);
  assign push = cmd_ch.valid && cmd_ch.ready && keep;
  assign q_valid = fill != '0;
  assign q_item = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !q_pop) begin
        fill <= fill + (QAW + 1)'(1);
      end else if (!push && q_pop) begin
        fill <= fill - (QAW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cls;
    end
  end

endmodule

// ----- rtl/core/wjs_back.sv -----
// Back end: table writes, weight issue sequencer and the skinning pipeline.
`timescale 1ns / 1ps
module wjs_back import wjs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  op_item_t     q_item,
  output logic         q_pop,
  wjs_point_if.source  point_ch
);

  typedef enum logic {ST_IDLE, ST_ISSUE} state_t;

  state_t          state;
  logic [WAW-1:0]  idx;
  logic [NW-1:0]   remain;

  logic            adv;
  logic            pipe_quiet;
  logic            iss_v;
  tag_t            iss_tag;
  logic [WAW-1:0]  iss_addr;
  logic            jw_we;
  logic            ww_we;
  weight_rec_t     w_wd;
  joint_rec_t      j_wd;
  weight_rec_t     w_rd;
  joint_rec_t      j_rd;

  logic a_v, b_v, c_v, d_v, e_v, f_v, g_v, h_v;
  tag_t a_tag, b_tag, c_tag, d_tag, e_tag, f_tag, g_tag;

  logic signed [31:0] b_vec [3];
  logic [15:0]        b_bias;

  logic signed [47:0] c_mp [3];
  logic signed [47:0] c_mn [3];
  logic signed [31:0] c_vec [3];
  logic signed [31:0] c_p [3];
  logic signed [15:0] c_q [3];
  logic signed [15:0] c_qw;
  logic [15:0]        c_bias;

  logic signed [35:0] d_t [3];
  logic signed [31:0] d_vec [3];
  logic signed [31:0] d_p [3];
  logic signed [15:0] d_q [3];
  logic signed [15:0] d_qw;
  logic [15:0]        d_bias;

  logic signed [51:0] e_w [3];
  logic signed [51:0] e_cp [3];
  logic signed [51:0] e_cn [3];
  logic signed [31:0] e_vec [3];
  logic signed [31:0] e_p [3];
  logic [15:0]        e_bias;

  logic signed [41:0] f_r [3];
  logic [15:0]        f_bias;

  logic signed [58:0] g_m [3];

  logic signed [63:0] acc [3];
  logic signed [63:0] acc_next [3];
  logic               jf;
  logic               jf_next;
  logic signed [63:0] h_acc [3];
  logic               h_jf;
  logic               h_rf;

  logic signed [49:0] cv_r [3];
  logic signed [53:0] u_r [3];
  logic signed [53:0] u_s [3];
  logic signed [63:0] s_r [3];
  logic signed [31:0] clamp [3];
  logic               sat;
  logic signed [16:0] bias_s;
  logic signed [31:0] jp [3];
  logic signed [15:0] jq [3];

  logic               out_v;
  logic signed [31:0] out_pt [3];
  logic [1:0]         out_fault;

  assign adv = !out_v || point_ch.ready;
  assign pipe_quiet = !a_v && !b_v;

  // Issue: a vertex enters one weight per advancing cycle; table writes wait
  // until no earlier table read is still outstanding.
  always_comb begin
    iss_v = 1'b0;
    iss_tag = '0;
    iss_addr = idx;
    q_pop = 1'b0;
    jw_we = 1'b0;
    ww_we = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_item.op)
            OP_JOINT: begin
              if (pipe_quiet) begin
                q_pop = 1'b1;
                jw_we = 1'b1;
              end
            end
            OP_WEIGHT: begin
              if (pipe_quiet) begin
                q_pop = 1'b1;
                ww_we = 1'b1;
              end
            end
            OP_COMPUTE: begin
              if (adv) begin
                q_pop = 1'b1;
                iss_v = 1'b1;
                iss_addr = WAW'(q_item.slot);
                iss_tag.first = 1'b1;
                if (q_item.range_fault || q_item.n == '0) begin
                  iss_tag.last = 1'b1;
                  iss_tag.range_fault = q_item.range_fault;
                end else begin
                  iss_tag.contrib = 1'b1;
                  iss_tag.last = q_item.n == NW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        if (adv) begin
          iss_v = 1'b1;
          iss_tag.contrib = 1'b1;
          iss_tag.last = remain == NW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      remain <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (iss_v && iss_tag.contrib && !iss_tag.last) begin
            state <= ST_ISSUE;
            idx <= WAW'(q_item.slot) + WAW'(1);
            remain <= q_item.n - NW'(1);
          end
        end
        ST_ISSUE: begin
          if (adv) begin
            idx <= idx + WAW'(1);
            remain <= remain - NW'(1);
            if (remain == NW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    w_wd.ox = q_item.pos_x;
    w_wd.oy = q_item.pos_y;
    w_wd.oz = q_item.pos_z;
    w_wd.joint_ref = q_item.joint_ref;
    w_wd.bias = q_item.bias;
    j_wd.px = q_item.pos_x;
    j_wd.py = q_item.pos_y;
    j_wd.pz = q_item.pos_z;
    j_wd.qx = q_item.rot_x;
    j_wd.qy = q_item.rot_y;
    j_wd.qz = q_item.rot_z;
    j_wd.qw = q_item.rot_w;
  end

  wjs_ram #(.WIDTH($bits(weight_rec_t)), .DEPTH(WEIGHT_SLOTS)) u_weight_ram (
    .clk   (clk),
    .we    (ww_we),
    .waddr (WAW'(q_item.slot)),
    .wdata (w_wd),
    .re    (adv),
    .raddr (iss_addr),
    .rdata (w_rd)
  );

  wjs_ram #(.WIDTH($bits(joint_rec_t)), .DEPTH(JOINT_SLOTS)) u_joint_ram (
    .clk   (clk),
    .we    (jw_we),
    .waddr (JAW'(q_item.slot)),
    .wdata (j_wd),
    .re    (adv),
    .raddr (JAW'(w_rd.joint_ref)),
    .rdata (j_rd)
  );

  always_comb begin
    jp[0] = j_rd.px;
    jp[1] = j_rd.py;
    jp[2] = j_rd.pz;
    jq[0] = j_rd.qx;
    jq[1] = j_rd.qy;
    jq[2] = j_rd.qz;
    bias_s = {1'b0, f_bias};
    for (int c = 0; c < 3; c++) begin
      cv_r[c] = 50'(c_mp[c]) - 50'(c_mn[c]) + 50'sd4096;
      u_r[c] = 54'(e_w[c]) + 54'(e_cp[c]) - 54'(e_cn[c]) + 54'sd8192;
      u_s[c] = u_r[c] >>> 14;
      acc_next[c] = (g_tag.first ? 64'sd0 : acc[c]) +
                    (g_tag.contrib ? 64'(g_m[c]) : 64'sd0);
    end
    jf_next = (g_tag.first ? 1'b0 : jf) | g_tag.joint_fault;
  end

  // Final rounding and clamp of the finished vertex.
  always_comb begin
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      s_r[c] = (h_acc[c] + 64'sd16384) >>> 15;
      if (s_r[c] > 64'sd2147483647) begin
        clamp[c] = 32'sh7fffffff;
        sat = 1'b1;
      end else if (s_r[c] < -64'sd2147483648) begin
        clamp[c] = 32'sh80000000;
        sat = 1'b1;
      end else begin
        clamp[c] = 32'(s_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      a_v <= iss_v;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v && g_tag.last;
      out_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag <= iss_tag;
      b_tag <= '{first: a_tag.first, last: a_tag.last, contrib: a_tag.contrib,
                 range_fault: a_tag.range_fault,
                 joint_fault: a_tag.contrib &&
                              (SUMW'(w_rd.joint_ref) >= SUMW'(JOINT_SLOTS))};
      b_vec[0] <= w_rd.ox;
      b_vec[1] <= w_rd.oy;
      b_vec[2] <= w_rd.oz;
      b_bias <= w_rd.bias;

      c_tag <= b_tag;
      c_mp[0] <= 48'(jq[1]) * 48'(b_vec[2]);
      c_mn[0] <= 48'(jq[2]) * 48'(b_vec[1]);
      c_mp[1] <= 48'(jq[2]) * 48'(b_vec[0]);
      c_mn[1] <= 48'(jq[0]) * 48'(b_vec[2]);
      c_mp[2] <= 48'(jq[0]) * 48'(b_vec[1]);
      c_mn[2] <= 48'(jq[1]) * 48'(b_vec[0]);
      c_qw <= j_rd.qw;
      c_bias <= b_bias;

      d_tag <= c_tag;
      d_qw <= c_qw;
      d_bias <= c_bias;

      e_tag <= d_tag;
      e_w[0] <= 52'(d_qw) * 52'(d_t[0]);
      e_w[1] <= 52'(d_qw) * 52'(d_t[1]);
      e_w[2] <= 52'(d_qw) * 52'(d_t[2]);
      e_cp[0] <= 52'(d_q[1]) * 52'(d_t[2]);
      e_cn[0] <= 52'(d_q[2]) * 52'(d_t[1]);
      e_cp[1] <= 52'(d_q[2]) * 52'(d_t[0]);
      e_cn[1] <= 52'(d_q[0]) * 52'(d_t[2]);
      e_cp[2] <= 52'(d_q[0]) * 52'(d_t[1]);
      e_cn[2] <= 52'(d_q[1]) * 52'(d_t[0]);
      e_bias <= d_bias;

      f_tag <= e_tag;
      f_bias <= e_bias;

      g_tag <= f_tag;

      for (int c = 0; c < 3; c++) begin
        c_vec[c] <= b_vec[c];
        c_p[c] <= jp[c];
        c_q[c] <= jq[c];
        d_t[c] <= 36'(cv_r[c] >>> 13);
        d_vec[c] <= c_vec[c];
        d_p[c] <= c_p[c];
        d_q[c] <= c_q[c];
        e_vec[c] <= d_vec[c];
        e_p[c] <= d_p[c];
        f_r[c] <= 42'(e_vec[c]) + 42'(u_s[c]) + 42'(e_p[c]);
        g_m[c] <= 59'(f_r[c]) * 59'(bias_s);
      end

      if (g_v) begin
        jf <= jf_next;
        for (int c = 0; c < 3; c++) begin
          acc[c] <= acc_next[c];
        end
        if (g_tag.last) begin
          h_jf <= jf_next;
          h_rf <= g_tag.range_fault;
          for (int c = 0; c < 3; c++) begin
            h_acc[c] <= acc_next[c];
          end
        end
      end

      if (h_rf || h_jf) begin
        out_fault <= h_rf ? FAULT_RANGE : FAULT_JOINT;
        for (int c = 0; c < 3; c++) begin
          out_pt[c] <= '0;
        end
      end else begin
        out_fault <= sat ? FAULT_SAT : FAULT_OK;
        for (int c = 0; c < 3; c++) begin
          out_pt[c] <= clamp[c];
        end
      end
    end
  end

  assign point_ch.valid = out_v;
  assign point_ch.point_x = out_pt[0];
  assign point_ch.point_y = out_pt[1];
  assign point_ch.point_z = out_pt[2];
  assign point_ch.fault = out_fault;

endmodule

// ----- rtl/core/weighted_joint_vertex_skinning_unit.sv -----
// Top level of the weighted joint vertex skinning unit.
`timescale 1ns / 1ps
// The unit holds a joint table (position and unit quaternion) and a weight
// table (offset, joint reference and bias), both loaded by write items, and
// turns each compute item into one skinned Q16.16 point. Write items and
// unknown commands give no result, and a write to a slot beyond its table is
// dropped. Both tables come out of reset with undefined contents and no
// clearing pass: a vertex must only use entries that have been written. A
// four-entry queue separates the accepting front end from the back end, so
// items keep being taken until the queue is full while a result waits at
// the output. The back end issues one weight-table read per cycle while the
// output is not stalled, so a vertex with n weights takes n issued reads
// (one read for zero weights or an out-of-range weight span), and
// consecutive vertices overlap in the nine-stage arithmetic pipeline. A table
// write waits until the table reads of the vertex before it have completed.
// While a finished point is not taken, the arithmetic pipeline and the issue
// of vertices hold.
module weighted_joint_vertex_skinning_unit import wjs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  wjs_cmd_if.sink     cmd_ch,
  wjs_point_if.source point_ch
);

  logic     q_valid;
  op_item_t q_item;
  logic     q_pop;

  // Front end classifies each item and saturates the weight count.
  wjs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd_ch  (cmd_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // Back end owns both tables and the arithmetic pipeline.
  wjs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .point_ch (point_ch)
  );

endmodule

// ----- rtl/core/wjs_checker.sv -----
// Port-level checks of the skinning unit and their binding to the top level.
`timescale 1ns / 1ps
`include "weighted_joint_vertex_skinning_unit_defines.svh"
module wjs_checker import wjs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] px,
  input logic signed [31:0] py,
  input logic signed [31:0] pz,
  input logic [1:0]         fault
);

  `WJS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "point item dropped while stalled")
  `WJS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(px) && $stable(py) && $stable(pz) && $stable(fault), "point item changed while stalled")
  `WJS_ASSERT_NOW(a_fault_zero, clk, rst, out_valid && (fault == FAULT_RANGE || fault == FAULT_JOINT), px == 32'sd0 && py == 32'sd0 && pz == 32'sd0, "faulted point is not zero")
  `WJS_ASSERT_NOW(a_sat_clamp, clk, rst, out_valid && fault == FAULT_SAT, px == 32'sh7fffffff || px == 32'sh80000000 || py == 32'sh7fffffff || py == 32'sh80000000 || pz == 32'sh7fffffff || pz == 32'sh80000000, "saturated point has no clamped component")

endmodule

bind weighted_joint_vertex_skinning_unit wjs_checker u_wjs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (point_ch.valid),
  .out_ready (point_ch.ready),
  .px        (point_ch.point_x),
  .py        (point_ch.point_y),
  .pz        (point_ch.point_z),
  .fault     (point_ch.fault)
);
